/* src/sha_pkg.sv */
// Package for the SHA-256 hasher: payload types, constants, a rotate-right function.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       push;       // write push_data into the block buffer
    logic [7:0] push_data;
    logic       start;      // load working variables from hash words
    logic       round;      // run one compression round
    logic       finish;     // add working variables into hash words
    logic       add_total;  // count one message byte
    logic       reinit;     // return to initial vector, clear counters
    logic       shift_out;  // rotate hash words for digest output
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0]  bytes_in_block;
    logic [6:0]  round_index;
    logic [63:0] bit_length;
  } dp_status_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam int Rounds = 64;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* src/sha_datapath.sv */
// SHA-256 datapath: block buffer, schedule, working variables, hash words, counters.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [31:0] head_word
);

  logic [31:0] hash_words [8];
  logic [31:0] vars [8];
  logic [31:0] window [16];
  logic [5:0]  bytes_in_block;
  logic [60:0] total;
  logic [6:0]  round_index;

  logic [3:0]  r4;
  logic [31:0] x15, x2, x7, x16, g0, g1, w, s1, ch, t1, s0, mj, t2;
  logic [3:0]  widx;
  logic [4:0]  bsh;

  assign r4   = round_index[3:0];
  assign x16  = window[r4];
  assign x15  = window[r4 + 4'd1];
  assign x7   = window[r4 + 4'd9];
  assign x2   = window[r4 + 4'd14];
  assign g0   = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign g1   = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign w    = round_index[6:4] == 3'd0 ? x16 : x16 + g0 + x7 + g1;
  assign s1   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
  assign ch   = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign t1   = vars[7] + s1 + ch + RoundK[round_index[5:0]] + w;
  assign s0   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
  assign mj   = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t2   = s0 + mj;
  assign widx = bytes_in_block[5:2];
  assign bsh  = {~bytes_in_block[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (bytes_in_block[1:0] == 2'd0) begin
        window[widx] <= {cmd.push_data, 24'd0};
      end else begin
        window[widx] <= window[widx] | ({24'd0, cmd.push_data} << bsh);
      end
    end else if (cmd.round) begin
      window[r4] <= w;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) vars[i] <= hash_words[i];
    end else if (cmd.round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= IV[i];
      bytes_in_block <= '0;
      total          <= '0;
      round_index    <= '0;
    end else begin
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + vars[i];
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) hash_words[i] <= hash_words[i + 1];
        hash_words[7] <= hash_words[0];
      end
      if (cmd.push) bytes_in_block <= bytes_in_block + 6'd1;
      if (cmd.add_total) total <= total + 61'd1;
      if (cmd.start) begin
        round_index <= '0;
      end else if (cmd.round) begin
        round_index <= round_index + 7'd1;
      end
    end
  end

  assign status.bytes_in_block = bytes_in_block;
  assign status.round_index    = round_index;
  assign status.bit_length     = {total, 3'b000};
  assign head_word             = hash_words[0];

endmodule

/* src/sha_controller.sv */
// SHA-256 controller: input handshake, padding sequence, compression and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_controller
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [2:0] out_index,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SPad   = 3'd1;
  localparam logic [2:0] SLen   = 3'd2;
  localparam logic [2:0] SStart = 3'd3;
  localparam logic [2:0] SRound = 3'd4;
  localparam logic [2:0] SFin   = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  logic [2:0] state, state_next, ret, ret_next;
  logic       pend_end, pend_end_next;
  logic [2:0] len_cnt, len_cnt_next, oidx, oidx_next;
  logic       accept;
  logic [5:0] len_shift;

  assign in_stall  = state != SIdle;
  assign accept    = in_valid && !in_stall;
  assign out_valid = state == SOut;
  assign out_index = oidx;
  assign len_shift = {~len_cnt, 3'b000};

  always_comb begin
    cmd           = '0;
    state_next    = state;
    ret_next      = ret;
    pend_end_next = pend_end;
    len_cnt_next  = len_cnt;
    oidx_next     = oidx;
    case (state)
      SIdle: begin
        if (accept) begin
          cmd.push      = in_data.has_byte;
          cmd.push_data = in_data.msg_byte;
          cmd.add_total = in_data.has_byte;
          pend_end_next = in_data.end_of_message;
          if (in_data.has_byte && status.bytes_in_block == 6'd63) begin
            ret_next   = in_data.end_of_message ? SPad : SIdle;
            state_next = SStart;
          end else if (in_data.end_of_message) begin
            state_next = SPad;
          end
        end
      end
      SPad: begin
        // First pad byte is 0x80, then zeros until the length field.
        cmd.push      = 1'b1;
        cmd.push_data = pend_end ? PadByte : 8'd0;
        pend_end_next = 1'b0;
        len_cnt_next  = '0;
        if (status.bytes_in_block == 6'd63) begin
          ret_next   = SPad;
          state_next = SStart;
        end else if (status.bytes_in_block + 6'd1 == LenStart) begin
          state_next = SLen;
        end
      end
      SLen: begin
        cmd.push      = 1'b1;
        cmd.push_data = 8'(status.bit_length >> len_shift);
        len_cnt_next  = len_cnt + 3'd1;
        if (len_cnt == 3'd7) begin
          ret_next   = SOut;
          state_next = SStart;
        end
      end
      SStart: begin
        cmd.start  = 1'b1;
        state_next = SRound;
      end
      SRound: begin
        cmd.round = 1'b1;
        if (status.round_index == 7'(Rounds - 1)) state_next = SFin;
      end
      SFin: begin
        cmd.finish = 1'b1;
        oidx_next  = '0;
        state_next = ret;
      end
      SOut: begin
        if (!out_stall) begin
          cmd.shift_out = 1'b1;
          oidx_next     = oidx + 3'd1;
          if (oidx == 3'd7) begin
            cmd.shift_out = 1'b0;
            cmd.reinit    = 1'b1;
            state_next    = SIdle;
          end
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SIdle;
      ret      <= SIdle;
      pend_end <= 1'b0;
      len_cnt  <= '0;
      oidx     <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      pend_end <= pend_end_next;
      len_cnt  <= len_cnt_next;
      oidx     <= oidx_next;
    end
  end

endmodule

/* src/sha256_message_hasher.sv */
// Channel | direction | payload
// in      | input     | in_item_t: msg_byte, has_byte, end_of_message
// out     | output    | out_item_t: digest_word, word_index, last_word
// Bytes are accepted one per cycle while idle; the 64th byte of a block stalls input for
// the one-round-per-cycle compression. A message end adds padding bytes at one per
// cycle, one or two compressions, then eight digest beats.
// Synchronous reset restores the initial vector; input stalls while busy.
// Depends on sha_pkg, sha_controller, sha_datapath.
`timescale 1ns / 1ps
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] head_word;
  logic [2:0]  idx;

  sha_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_stall, .out_valid,
    .out_index(idx), .cmd, .status
  );

  sha_datapath u_dp (.clk, .rst, .cmd, .status, .head_word);

  assign out_data.digest_word = head_word;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = idx == 3'd7;

endmodule

/* dv/sha256_message_hasher_tb.sv */
// Testbench for sha256_message_hasher: drives byte beats with random gaps,
// predicts digest words with a behavioral SHA-256 and checks every output beat.
// Depends on sha_pkg (payload types) and the hasher RTL.
`timescale 1ns / 1ps
module sha256_message_hasher_tb;
  import sha_pkg::*;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;

  sha256_message_hasher dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] hash_st [8];
  logic [31:0] blk_words [16];
  logic [5:0]  blk_fill;
  logic [60:0] byte_count;

  in_item_t  pending_beats [$];
  out_item_t expected_words [$];
  int        err_count = 0;
  bit        stim_done = 1'b0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    int idx;
    idx = blk_fill[5:2];
    if (blk_fill[1:0] == 2'd0) blk_words[idx] = '0;
    blk_words[idx][(3 - blk_fill[1:0]) * 8 +: 8] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress();
  endtask

  task automatic hasher_reset();
    for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
    blk_fill = '0;
    byte_count = '0;
  endtask

  task automatic predict_beat(in_item_t it);
    logic [63:0] bit_len;
    out_item_t o;
    if (it.has_byte) begin
      absorb_byte(it.msg_byte);
      byte_count = byte_count + 61'd1;
    end
    if (!it.end_of_message) return;
    bit_len = {byte_count, 3'b000};
    absorb_byte(8'h80);
    while (blk_fill != 6'd56) absorb_byte(8'h00);
    for (int k = 0; k < 8; k++) absorb_byte(bit_len[(7 - k) * 8 +: 8]);
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_st[k];
      o.word_index = 3'(k);
      o.last_word = (k == 7);
      expected_words.push_back(o);
    end
    hasher_reset();
  endtask

  task automatic queue_msg(int len, int mode);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      case (mode)
        1: it.msg_byte = 8'hff;
        2: it.msg_byte = 8'h00;
        default: it.msg_byte = 8'($urandom);
      endcase
      it.has_byte = 1'b1;
      it.end_of_message = (i == len - 1) && ($urandom_range(0, 1) == 1);
      pending_beats.push_back(it);
      if (it.end_of_message) return;
    end
    it.msg_byte = 8'($urandom);
    it.has_byte = 1'b0;
    it.end_of_message = 1'b1;
    pending_beats.push_back(it);
  endtask

  // Driver: one beat at a time, random gap after each.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_beat(in_data);
        void'(pending_beats.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the stalled beat.
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if ((in_valid && !in_stall ? pending_beats.size() : pending_beats.size()) > 0
                   && !(in_valid && !in_stall && pending_beats.size() == 0)) begin
        in_valid <= 1'b1;
        in_data <= pending_beats[0];
        in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end else begin
        in_valid <= 1'b0;
        if (pending_beats.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // Monitor: random stall on the output side.
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest beat %h", out_data);
          err_count++;
        end else begin
          out_item_t e;
          e = expected_words.pop_front();
          if (out_data.digest_word !== e.digest_word) begin
            $error("digest_word exp %h got %h", e.digest_word, out_data.digest_word);
            err_count++;
          end
          if (out_data.word_index !== e.word_index) begin
            $error("word_index exp %0d got %0d", e.word_index, out_data.word_index);
            err_count++;
          end
          if (out_data.last_word !== e.last_word) begin
            $error("last_word exp %0d got %0d", e.last_word, out_data.last_word);
            err_count++;
          end
        end
        out_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    in_item_t it;
    int len;
    hasher_reset();
    // Directed: empty message, idle beat, single bytes at the extremes,
    // and short messages of 0xff, 0x00 and random bytes.
    it = '{msg_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1};
    pending_beats.push_back(it);
    it = '{msg_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0};
    pending_beats.push_back(it);
    it = '{msg_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1};
    pending_beats.push_back(it);
    it = '{msg_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b1};
    pending_beats.push_back(it);
    queue_msg(3, 1);
    queue_msg(4, 2);
    queue_msg(3, 0);
    // Random: mostly messages with some idle noise; a few long ones
    // cross the 55/56/64-byte boundaries.
    while (pending_beats.size() < 220) begin
      if ($urandom_range(0, 9) == 0) begin
        it = '{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b0};
        pending_beats.push_back(it);
      end else begin
        case ($urandom_range(0, 5))
          0: len = $urandom_range(54, 66);
          1: len = $urandom_range(110, 130);
          default: len = $urandom_range(0, 12);
        endcase
        // Keep the total beat count close to the target.
        if (len > 220 - pending_beats.size()) len = 220 - pending_beats.size();
        queue_msg(len, 0);
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_words.size() == 0);
    repeat (300) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sha256_message_hasher.f */
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_controller.sv
src/sha256_message_hasher.sv
dv/sha256_message_hasher_tb.sv
